// File: hdl/b64c_pkg.sv
// Shared types, codes and character tables for the Base64 codec.
package b64c_pkg;

  localparam int unsigned QueueDepthDefault = 4;

  localparam logic ActData = 1'b0;
  localparam logic ActEnd  = 1'b1;

  localparam logic ModeEncode = 1'b0;
  localparam logic ModeDecode = 1'b1;

  localparam logic [1:0] ErrNone = 2'd0;
  localparam logic [1:0] ErrChar = 2'd1;
  localparam logic [1:0] ErrPad  = 2'd2;

  localparam logic [7:0] CharPad   = 8'h3D;
  localparam logic [7:0] CharPlus  = 8'h2B;
  localparam logic [7:0] CharSlash = 8'h2F;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_status;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  // Work queued for one input item: n results, the first data bytes in b0..b2,
  // and when has_status is set the final result is the status.
  typedef struct packed {
    logic [2:0] n;
    logic       has_status;
    logic [1:0] err;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } job_t;

  typedef struct packed {
    logic       ok;
    logic [5:0] val;
  } dec_t;

  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] c;
    if (v < 6'd26) begin
      c = {2'b00, v} + 8'h41;
    end else if (v < 6'd52) begin
      c = {2'b00, v} + 8'h47;
    end else if (v < 6'd62) begin
      c = {2'b00, v} - 8'd4;
    end else if (v == 6'd62) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

  function automatic dec_t dec_char(input logic [7:0] c);
    dec_t d;
    d.ok  = 1'b1;
    d.val = '0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      d.val = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      d.val = 6'(c - 8'h47);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      d.val = 6'(c + 8'd4);
    end else if (c == CharPlus) begin
      d.val = 6'd62;
    end else if (c == CharSlash) begin
      d.val = 6'd63;
    end else begin
      d.ok = 1'b0;
    end
    return d;
  endfunction

endpackage

// File: hdl/b64c_front.sv
// Front end: accepts items, keeps the stream state and pushes a job for each item with results.
module b64c_front import b64c_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cfg_valid_i,
  input  logic     cfg_data_i,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  output logic     in_stall_o,
  input  logic     full_i,
  output logic     push_o,
  output job_t     job_o
);

  logic       mode_q;
  logic [1:0] phase_q, phase_d;
  logic [5:0] carry_q, carry_d;
  logic       await_q, await_d;
  logic [1:0] sticky_q, sticky_d;
  logic       accept;
  job_t       job;
  dec_t       dec;
  logic [7:0] b;

  assign in_stall_o = full_i;
  assign accept     = in_valid_i && !full_i;
  assign b          = in_item_i.data_byte;
  assign dec        = dec_char(b);

  always_comb begin
    job      = '0;
    phase_d  = phase_q;
    carry_d  = carry_q;
    await_d  = await_q;
    sticky_d = sticky_q;
    if (in_item_i.action == ActEnd) begin
      job.has_status = 1'b1;
      job.err        = sticky_q;
      job.n          = 3'd1;
      if (mode_q == ModeEncode) begin
        if (sticky_q == ErrNone && phase_q != 2'd0) begin
          job.b0 = enc_char(carry_q);
          job.b1 = CharPad;
          job.b2 = CharPad;
          job.n  = (phase_q == 2'd1) ? 3'd4 : 3'd3;
        end
      end else if (sticky_q == ErrNone && (phase_q != 2'd0 || await_q)) begin
        job.err = ErrPad;
      end
      phase_d  = '0;
      carry_d  = '0;
      await_d  = 1'b0;
      sticky_d = ErrNone;
    end else if (sticky_q != ErrNone) begin
      job.n = 3'd0;
    end else if (mode_q == ModeEncode) begin
      job.n = 3'd1;
      unique case (phase_q)
        2'd0: begin
          job.b0  = enc_char(b[7:2]);
          carry_d = {b[1:0], 4'b0000};
          phase_d = 2'd1;
        end
        2'd1: begin
          job.b0  = enc_char({carry_q[5:4], b[7:4]});
          carry_d = {b[3:0], 2'b00};
          phase_d = 2'd2;
        end
        default: begin
          job.b0  = enc_char({carry_q[5:2], b[7:6]});
          job.b1  = enc_char(b[5:0]);
          job.n   = 3'd2;
          carry_d = '0;
          phase_d = 2'd0;
        end
      endcase
    end else if (await_q) begin
      if (b == CharPad) begin
        await_d = 1'b0;
        phase_d = '0;
        carry_d = '0;
      end else begin
        sticky_d = ErrPad;
      end
    end else if (dec.ok) begin
      unique case (phase_q)
        2'd0: begin
          carry_d = dec.val;
          phase_d = 2'd1;
        end
        2'd1: begin
          job.n   = 3'd1;
          job.b0  = {carry_q, dec.val[5:4]};
          carry_d = {2'b00, dec.val[3:0]};
          phase_d = 2'd2;
        end
        2'd2: begin
          job.n   = 3'd1;
          job.b0  = {carry_q[3:0], dec.val[5:2]};
          carry_d = {4'b0000, dec.val[1:0]};
          phase_d = 2'd3;
        end
        default: begin
          job.n   = 3'd1;
          job.b0  = {carry_q[1:0], dec.val};
          carry_d = '0;
          phase_d = 2'd0;
        end
      endcase
    end else if (b == CharPad) begin
      if (phase_q == 2'd3) begin
        phase_d = '0;
        carry_d = '0;
      end else if (phase_q == 2'd2) begin
        await_d = 1'b1;
      end else begin
        sticky_d = ErrPad;
      end
    end else begin
      sticky_d = ErrChar;
    end
  end

  assign job_o  = job;
  assign push_o = accept && (job.n != 3'd0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeEncode;
      phase_q  <= '0;
      carry_q  <= '0;
      await_q  <= 1'b0;
      sticky_q <= ErrNone;
    end else if (cfg_valid_i) begin
      // A mode write always restarts the stream.
      mode_q   <= cfg_data_i;
      phase_q  <= '0;
      carry_q  <= '0;
      await_q  <= 1'b0;
      sticky_q <= ErrNone;
    end else if (accept) begin
      phase_q  <= phase_d;
      carry_q  <= carry_d;
      await_q  <= await_d;
      sticky_q <= sticky_d;
    end
  end

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_item_i.action == ActEnd |=>
      phase_q == 2'd0 && !await_q && sticky_q == ErrNone)
    else $error("stream state not cleared after end of stream");

endmodule

// File: hdl/b64c_fifo.sv
// Short job queue between the front end and the output sequencer.
module b64c_fifo import b64c_pkg::*; #(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t wdata_i,
  input  logic pop_i,
  output job_t rdata_o,
  output logic empty_o,
  output logic full_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == Full);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> count_q < Full)
    else $error("job queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> count_q != '0)
    else $error("job queue underflow");

endmodule

// File: hdl/b64c_back.sv
// Output sequencer: steps through each queued job, one result transfer a cycle while not stalled.
module b64c_back import b64c_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  job_t      job_i,
  input  logic      empty_i,
  output logic      pop_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_item_q;
  logic       load;
  logic       final_entry;
  out_item_t  entry;

  assign load        = !empty_i && (!out_valid_q || !out_stall_i);
  assign final_entry = ({1'b0, idx_q} + 3'd1) == job_i.n;
  assign pop_o       = load && final_entry;

  always_comb begin
    entry            = '0;
    entry.last       = final_entry;
    if (final_entry && job_i.has_status) begin
      entry.is_status  = 1'b1;
      entry.error_code = job_i.err;
    end else begin
      case (idx_q)
        2'd0:    entry.out_byte = job_i.b0;
        2'd1:    entry.out_byte = job_i.b1;
        default: entry.out_byte = job_i.b2;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      idx_q       <= final_entry ? '0 : idx_q + 1'b1;
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_item_q <= entry;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_item_q.is_status |-> out_item_q.last)
    else $error("status result without last");

  a_job_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> job_i.n != 3'd0)
    else $error("empty job reached the output sequencer");

endmodule

// File: hdl/base64_codec_unit.sv
// The first result of an item passes through the job queue and then the output register.
// Throughput: one result transfer per cycle while out_stall_i is low; an item yields up to four
// results; encoding is limited by the single result port of the output sequencer.
// Items are taken every cycle while the job queue (QueueDepth entries) has room.
// Reset selects encode mode, clears the stream state, the job queue and the output valid flag.
module base64_codec_unit import b64c_pkg::*; #(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  job_t push_job, head_job;
  logic push, pop, empty, full;

  assign cfg_ready_o = 1'b1;

  b64c_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .in_stall_o  (in_stall_o),
    .full_i      (full),
    .push_o      (push),
    .job_o       (push_job)
  );

  b64c_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_job),
    .pop_i   (pop),
    .rdata_o (head_job),
    .empty_o (empty),
    .full_o  (full)
  );

  b64c_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (head_job),
    .empty_i     (empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
